[sv/gpfb_pkg.sv]
package gpfb_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_DRAW  = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] col_x;
    logic [6:0] row_y;
    logic [7:0] char_code;
    logic [2:0] read_page;
    logic [6:0] read_column;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       char_accepted;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_CLEAR,
    ST_DRAW_RD,
    ST_DRAW_WR,
    ST_READ_RD,
    ST_READ_CAP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic res_clear;
    logic clr_start;
    logic clr_step;
    logic glyph_wr;
    logic byte_rd;
    logic res_read;
  } ctrl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic code_ok;
    logic sweep_last;
    logic step_last;
  } dp_status_t;

  localparam logic [7:0] CodeFirst = 8'h20;
  localparam logic [7:0] CodeLast  = 8'h7A;
  // two bytes (page halves) per glyph column, five columns
  localparam logic [3:0] StepLast  = 4'd9;

  function automatic logic [7:0] glyph_col(logic [7:0] code, logic [2:0] col);
    logic [4:0][7:0] g;
    g = '0;
    case (code)
      8'h25: g = {8'h23, 8'h13, 8'h08, 8'h64, 8'h62}; // %
      8'h2E: g = {8'h00, 8'h60, 8'h60, 8'h00, 8'h00}; // .
      8'h30: g = {8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
      8'h31: g = {8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
      8'h32: g = {8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
      8'h33: g = {8'h21, 8'h41, 8'h45, 8'h4B, 8'h31};
      8'h34: g = {8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
      8'h35: g = {8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
      8'h36: g = {8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
      8'h37: g = {8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
      8'h38: g = {8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      8'h39: g = {8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
      8'h3A: g = {8'h00, 8'h36, 8'h36, 8'h00, 8'h00}; // :
      8'h43: g = {8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}; // C
      8'h48: g = {8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F}; // H
      8'h54: g = {8'h01, 8'h01, 8'h7F, 8'h01, 8'h01}; // T
      default: g = '0;
    endcase
    // leftmost column sits in the top element
    return g[3'd4 - col];
  endfunction

endpackage

[sv/glyph_page_framebuffer_blit.sv]
// From accept to out_strobe: read passes DECODE, READ_RD, READ_CAP and DONE; draw
// does ten byte read-modify-writes (read state, write state) on the frame memory;
// clear zeroes memory one byte per cycle; other ops, rejected draws go to DONE.
// busy drops the cycle after the strobe, so a new request can be accepted in that cycle.
// After reset busy stays high while the memory is zeroed.
// Results cannot be stalled by the receiver.
module glyph_page_framebuffer_blit #(
  parameter int COLUMNS = 128,
  parameter int ROWS    = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  gpfb_pkg::in_item_t   in_item,
  output logic                 out_strobe,
  output gpfb_pkg::out_item_t  out_item
);

  gpfb_pkg::ctrl_cmd_t  cmd;
  gpfb_pkg::dp_status_t status;

  gpfb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  gpfb_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .status   (status),
    .out_item (out_item)
  );

endmodule

[sv/gpfb_ctrl.sv]
module gpfb_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  gpfb_pkg::dp_status_t  status,
  output gpfb_pkg::ctrl_cmd_t   cmd,
  output logic                  busy,
  output logic                  out_strobe
);

  gpfb_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gpfb_pkg::ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gpfb_pkg::ST_INIT: begin
        if (status.sweep_last) state_nxt = gpfb_pkg::ST_IDLE;
      end
      gpfb_pkg::ST_IDLE: begin
        if (start) state_nxt = gpfb_pkg::ST_DECODE;
      end
      gpfb_pkg::ST_DECODE: begin
        case (status.op)
          gpfb_pkg::OP_CLEAR: state_nxt = gpfb_pkg::ST_CLEAR;
          gpfb_pkg::OP_DRAW: begin
            state_nxt = status.code_ok ? gpfb_pkg::ST_DRAW_RD : gpfb_pkg::ST_DONE;
          end
          gpfb_pkg::OP_READ: state_nxt = gpfb_pkg::ST_READ_RD;
          default: state_nxt = gpfb_pkg::ST_DONE;
        endcase
      end
      gpfb_pkg::ST_CLEAR: begin
        if (status.sweep_last) state_nxt = gpfb_pkg::ST_DONE;
      end
      gpfb_pkg::ST_DRAW_RD: state_nxt = gpfb_pkg::ST_DRAW_WR;
      gpfb_pkg::ST_DRAW_WR: begin
        state_nxt = status.step_last ? gpfb_pkg::ST_DONE : gpfb_pkg::ST_DRAW_RD;
      end
      gpfb_pkg::ST_READ_RD: state_nxt = gpfb_pkg::ST_READ_CAP;
      gpfb_pkg::ST_READ_CAP: state_nxt = gpfb_pkg::ST_DONE;
      gpfb_pkg::ST_DONE: state_nxt = gpfb_pkg::ST_IDLE;
      default: state_nxt = gpfb_pkg::ST_INIT;
    endcase
  end

  always_comb begin
    cmd        = '0;
    busy       = 1'b1;
    out_strobe = 1'b0;
    case (state_r)
      gpfb_pkg::ST_INIT: cmd.clr_step = 1'b1;
      gpfb_pkg::ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      gpfb_pkg::ST_DECODE: begin
        cmd.res_clear = 1'b1;
        cmd.clr_start = 1'b1;
      end
      gpfb_pkg::ST_CLEAR: cmd.clr_step = 1'b1;
      gpfb_pkg::ST_DRAW_RD: ;
      gpfb_pkg::ST_DRAW_WR: cmd.glyph_wr = 1'b1;
      gpfb_pkg::ST_READ_RD: cmd.byte_rd = 1'b1;
      gpfb_pkg::ST_READ_CAP: cmd.res_read = 1'b1;
      gpfb_pkg::ST_DONE: out_strobe = 1'b1;
      default: ;
    endcase
  end

endmodule

[sv/gpfb_dp.sv]
module gpfb_dp #(
  parameter int COLUMNS = 128,
  parameter int ROWS    = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  gpfb_pkg::in_item_t    in_item,
  input  gpfb_pkg::ctrl_cmd_t   cmd,
  output gpfb_pkg::dp_status_t  status,
  output gpfb_pkg::out_item_t   out_item
);

  localparam int Pages     = (ROWS + 7) / 8;
  localparam int StoreSize = COLUMNS * Pages;
  localparam int AW        = $clog2(StoreSize);
  localparam int LastBits  = ROWS - (Pages - 1) * 8;
  localparam logic [7:0] LastMask = 8'((1 << LastBits) - 1);

  gpfb_pkg::in_item_t  item_r;
  gpfb_pkg::out_item_t res_r;
  logic [3:0]          step_r;
  logic [AW-1:0]       sweep_r;
  logic [7:0]          mem [StoreSize];
  logic [7:0]          mem_q_r;

  logic [2:0]    col;
  logic          half;
  logic [8:0]    px;
  logic [4:0]    gpage;
  logic          g_ok;
  logic [AW-1:0] gaddr;
  logic [7:0]    gbyte;
  logic [15:0]   shifted;
  logic [7:0]    pix;
  logic [7:0]    pmask;
  logic [7:0]    wdata;
  logic          r_ok;
  logic [AW-1:0] raddr;
  logic [AW-1:0] rd_addr;
  logic          code_ok;

  assign col     = step_r[3:1];
  assign half    = step_r[0];
  assign px      = {1'b0, item_r.col_x} + {6'd0, col};
  assign gpage   = {1'b0, item_r.row_y[6:3]} + {4'd0, half};
  assign g_ok    = (int'(px) < COLUMNS) && (int'(gpage) < Pages);
  assign gaddr   = g_ok ? AW'(int'(gpage) * COLUMNS + int'(px)) : '0;
  assign gbyte   = gpfb_pkg::glyph_col(item_r.char_code, col);
  assign shifted = {8'd0, gbyte} << item_r.row_y[2:0];
  assign pix     = half ? shifted[15:8] : shifted[7:0];
  // rows past the bottom edge on a partial last page
  assign pmask   = (int'(gpage) == Pages - 1) ? LastMask : 8'hFF;
  assign wdata   = mem_q_r | (pix & pmask);

  assign r_ok    = (int'(item_r.read_page) < Pages) && (int'(item_r.read_column) < COLUMNS);
  assign raddr   = r_ok ? AW'(int'(item_r.read_page) * COLUMNS + int'(item_r.read_column))
                        : '0;
  assign rd_addr = cmd.byte_rd ? raddr : gaddr;

  assign code_ok = (item_r.char_code >= gpfb_pkg::CodeFirst) &&
                   (item_r.char_code <= gpfb_pkg::CodeLast);

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      mem[sweep_r] <= 8'd0;
    end else if (cmd.glyph_wr && g_ok) begin
      mem[gaddr] <= wdata;
    end
    mem_q_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      sweep_r <= '0;
    end else begin
      if (cmd.load) begin
        step_r <= '0;
      end else if (cmd.glyph_wr) begin
        step_r <= step_r + 4'd1;
      end
      if (cmd.clr_start) begin
        sweep_r <= '0;
      end else if (cmd.clr_step) begin
        sweep_r <= sweep_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_item;
    end
    if (cmd.res_clear) begin
      res_r.read_data     <= 8'd0;
      res_r.char_accepted <= (item_r.op == gpfb_pkg::OP_DRAW) && code_ok;
    end else if (cmd.res_read) begin
      res_r.read_data <= r_ok ? mem_q_r : 8'd0;
    end
  end

  assign status.op         = item_r.op;
  assign status.code_ok    = code_ok;
  assign status.sweep_last = (sweep_r == AW'(StoreSize - 1));
  assign status.step_last  = (step_r == gpfb_pkg::StepLast);
  assign out_item          = res_r;

endmodule

[sv/gpfb_check.sv]
module gpfb_check (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_strobe,
  input gpfb_pkg::out_item_t  out_item
);

  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy && !out_strobe)
    else $error("busy not held after reset");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy && !out_strobe)
    else $error("request accepted without going busy");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result while idle");

  a_strobe_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe && !busy)
    else $error("no release after result");

  a_draw_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_item.char_accepted |-> out_item.read_data == 8'd0)
    else $error("draw result carries read data");

endmodule

bind glyph_page_framebuffer_blit gpfb_check u_check (.*);

[tb/sv/tb_blit_checker.sv]
`timescale 1ns / 1ps

module tb_blit_checker #(
  parameter int COLUMNS = 128,
  parameter int ROWS    = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  gpfb_pkg::in_item_t  in_item,
  input  logic                out_strobe,
  input  gpfb_pkg::out_item_t out_item,
  output int                  mismatch_count,
  output int                  pending
);

  localparam int PAGES = (ROWS + 7) / 8;

  logic [7:0]          pixel_bytes [COLUMNS*PAGES];
  gpfb_pkg::out_item_t expected_results [$];
  gpfb_pkg::out_item_t oldest;

  // 5x7 font, leftmost column in the top byte; codes without a glyph are blank
  function automatic logic [7:0] font_column(logic [7:0] code, int idx);
    logic [39:0] cols;
    case (code)
      8'h25:   cols = 40'h23_13_08_64_62;
      8'h2E:   cols = 40'h00_60_60_00_00;
      8'h30:   cols = 40'h3E_51_49_45_3E;
      8'h31:   cols = 40'h00_42_7F_40_00;
      8'h32:   cols = 40'h42_61_51_49_46;
      8'h33:   cols = 40'h21_41_45_4B_31;
      8'h34:   cols = 40'h18_14_12_7F_10;
      8'h35:   cols = 40'h27_45_45_45_39;
      8'h36:   cols = 40'h3C_4A_49_49_30;
      8'h37:   cols = 40'h01_71_09_05_03;
      8'h38:   cols = 40'h36_49_49_49_36;
      8'h39:   cols = 40'h06_49_49_29_1E;
      8'h3A:   cols = 40'h00_36_36_00_00;
      8'h43:   cols = 40'h3E_41_41_41_22;
      8'h48:   cols = 40'h7F_08_08_08_7F;
      8'h54:   cols = 40'h01_01_7F_01_01;
      default: cols = '0;
    endcase
    return cols[39 - 8*idx -: 8];
  endfunction

  function automatic void render_glyph(logic [7:0] x, logic [6:0] y, logic [7:0] code);
    int px;
    int py;
    logic [7:0] bits;
    for (int c = 0; c < 5; c++) begin
      px = int'(x) + c;
      if (px >= COLUMNS) continue;
      bits = font_column(code, c);
      for (int r = 0; r < 8; r++) begin
        py = int'(y) + r;
        if (bits[r] && py < ROWS) pixel_bytes[(py / 8) * COLUMNS + px][py % 8] = 1'b1;
      end
    end
  endfunction

  function automatic gpfb_pkg::out_item_t apply_request(gpfb_pkg::in_item_t req);
    gpfb_pkg::out_item_t res;
    res = '0;
    case (req.op)
      gpfb_pkg::OP_CLEAR: foreach (pixel_bytes[i]) pixel_bytes[i] = '0;
      gpfb_pkg::OP_DRAW: begin
        if (req.char_code >= gpfb_pkg::CodeFirst && req.char_code <= gpfb_pkg::CodeLast) begin
          res.char_accepted = 1'b1;
          render_glyph(req.col_x, req.row_y, req.char_code);
        end
      end
      gpfb_pkg::OP_READ: begin
        if (int'(req.read_page) < PAGES && int'(req.read_column) < COLUMNS)
          res.read_data = pixel_bytes[int'(req.read_page) * COLUMNS + int'(req.read_column)];
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void note_mismatch(string what, gpfb_pkg::out_item_t want,
                                        gpfb_pkg::out_item_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected data %02h accepted %b, got data %02h accepted %b",
               $realtime, what, want.read_data, want.char_accepted,
               got.read_data, got.char_accepted);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (pixel_bytes[i]) pixel_bytes[i] = '0;
      expected_results.delete();
      mismatch_count = 0;
    end else begin
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          note_mismatch("result with no request pending", '0, out_item);
        end else begin
          oldest = expected_results.pop_front();
          if (oldest.read_data !== out_item.read_data ||
              oldest.char_accepted !== out_item.char_accepted)
            note_mismatch("result mismatch", oldest, out_item);
        end
      end
      if (start && !busy) expected_results.push_back(apply_request(in_item));
    end
    pending = expected_results.size();
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

  localparam int RANDOM_REQS = 1030;
  localparam int QUIET_TAIL  = 150;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  gpfb_pkg::in_item_t  in_item;
  logic                out_strobe;
  gpfb_pkg::out_item_t out_item;
  int                  mismatch_count;
  int                  pending;

  logic [7:0] last_x;
  logic [6:0] last_y;
  string      glyph_chars = " %.0123456789:CHT";

  glyph_page_framebuffer_blit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  tb_blit_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_item       (in_item),
    .out_strobe    (out_strobe),
    .out_item      (out_item),
    .mismatch_count(mismatch_count),
    .pending       (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic gpfb_pkg::in_item_t make_req(gpfb_pkg::op_t op, logic [7:0] x,
                                                  logic [6:0] y, logic [7:0] code,
                                                  logic [2:0] pg, logic [6:0] col);
    gpfb_pkg::in_item_t req;
    req.op          = op;
    req.col_x       = x;
    req.row_y       = y;
    req.char_code   = code;
    req.read_page   = pg;
    req.read_column = col;
    return req;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance, start left high
  task automatic send_req(input gpfb_pkg::in_item_t req);
    logic taken;
    start   = 1'b1;
    in_item = req;
    forever begin
      taken = !busy;
      @(posedge clk);
      if (taken) break;
      @(negedge clk);
    end
    @(negedge clk);
  endtask

  task automatic idle_burst(input int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  function automatic gpfb_pkg::in_item_t random_req();
    gpfb_pkg::in_item_t req;
    int roll;
    int pick;
    req = make_req(gpfb_pkg::op_t'(2'($urandom)), 8'($urandom), 7'($urandom),
                   8'($urandom), 3'($urandom), 7'($urandom));
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      req.op = gpfb_pkg::OP_CLEAR;
    end else if (roll < 4) begin
      req.op = gpfb_pkg::op_t'(2'd3);
    end else if (roll < 52) begin
      req.op = gpfb_pkg::OP_DRAW;
      pick = $urandom_range(0, 9);
      if (pick < 8)
        req.char_code = glyph_chars[$urandom_range(0, glyph_chars.len() - 1)];
      else if (pick == 8)
        req.char_code = 8'($urandom_range(gpfb_pkg::CodeFirst, gpfb_pkg::CodeLast));
      if ($urandom_range(0, 99) < 85) req.col_x = 8'($urandom_range(0, 132));
      if ($urandom_range(0, 99) < 85) req.row_y = 7'($urandom_range(0, 66));
      last_x = req.col_x;
      last_y = req.row_y;
    end else begin
      req.op = gpfb_pkg::OP_READ;
      if ($urandom_range(0, 99) < 70) begin
        req.read_page   = 3'((int'(last_y) + $urandom_range(0, 7)) / 8);
        req.read_column = 7'(int'(last_x) + $urandom_range(0, 4));
      end
    end
    return req;
  endfunction

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    last_x  = '0;
    last_y  = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    send_req(make_req(gpfb_pkg::OP_READ,  8'd0,   7'd0,   8'h00, 3'd0, 7'd0));
    send_req(make_req(gpfb_pkg::OP_DRAW,  8'd0,   7'd0,   8'h25, 3'd0, 7'd0));
    send_req(make_req(gpfb_pkg::OP_READ,  8'd0,   7'd0,   8'h00, 3'd0, 7'd0));
    send_req(make_req(gpfb_pkg::OP_READ,  8'd0,   7'd0,   8'h00, 3'd0, 7'd4));
    // glyph straddling pages 0 and 1
    send_req(make_req(gpfb_pkg::OP_DRAW,  8'd10,  7'd3,   8'h48, 3'd0, 7'd0));
    send_req(make_req(gpfb_pkg::OP_READ,  8'd0,   7'd0,   8'h00, 3'd0, 7'd10));
    send_req(make_req(gpfb_pkg::OP_READ,  8'd0,   7'd0,   8'h00, 3'd1, 7'd10));
    // clipped at right and bottom edges
    send_req(make_req(gpfb_pkg::OP_DRAW,  8'd125, 7'd60,  8'h38, 3'd0, 7'd0));
    send_req(make_req(gpfb_pkg::OP_READ,  8'd0,   7'd0,   8'h00, 3'd7, 7'd127));
    send_req(make_req(gpfb_pkg::OP_READ,  8'd0,   7'd0,   8'h00, 3'd7, 7'd125));
    send_req(make_req(gpfb_pkg::OP_DRAW,  8'hFF,  7'h7F,  8'h54, 3'd0, 7'd0));
    // accepted code with no glyph, range limits, rejected codes
    send_req(make_req(gpfb_pkg::OP_DRAW,  8'd20,  7'd8,   8'h41, 3'd0, 7'd0));
    send_req(make_req(gpfb_pkg::OP_READ,  8'd0,   7'd0,   8'h00, 3'd1, 7'd20));
    send_req(make_req(gpfb_pkg::OP_DRAW,  8'd30,  7'd16,  gpfb_pkg::CodeFirst, 3'd0, 7'd0));
    send_req(make_req(gpfb_pkg::OP_DRAW,  8'd30,  7'd16,  gpfb_pkg::CodeLast,  3'd0, 7'd0));
    send_req(make_req(gpfb_pkg::OP_DRAW,  8'd30,  7'd16,  8'h1F, 3'd0, 7'd0));
    send_req(make_req(gpfb_pkg::OP_DRAW,  8'd30,  7'd16,  8'h7B, 3'd0, 7'd0));
    send_req(make_req(gpfb_pkg::OP_DRAW,  8'd30,  7'd16,  8'hFF, 3'd0, 7'd0));
    send_req(make_req(gpfb_pkg::op_t'(2'd3), 8'hFF, 7'h7F, 8'hFF, 3'd7, 7'd127));
    send_req(make_req(gpfb_pkg::OP_READ,  8'hFF,  7'h7F,  8'hFF, 3'd0, 7'd0));
    send_req(make_req(gpfb_pkg::OP_CLEAR, 8'd0,   7'd0,   8'h00, 3'd0, 7'd0));
    send_req(make_req(gpfb_pkg::OP_READ,  8'd0,   7'd0,   8'h00, 3'd0, 7'd0));

    for (int n = 0; n < RANDOM_REQS; n++) begin
      send_req(random_req());
      if (n < RANDOM_REQS - QUIET_TAIL && $urandom_range(0, 99) < 30)
        idle_burst($urandom_range(1, 11));
    end
    start = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (mismatch_count == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
